[design/pwfp_pkg.sv]
// ----------------------------------------------------------------------------
// pwfp_pkg - shared types and codes for the protobuf wire field parser
// Item structs for both ports, the front-to-back token and the result codes.
// ----------------------------------------------------------------------------
package pwfp_pkg;

	// depth of the queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// result kinds
	localparam logic [1:0] KIND_SCALAR  = 2'd0;
	localparam logic [1:0] KIND_HEADER  = 2'd1;
	localparam logic [1:0] KIND_PAYLOAD = 2'd2;
	localparam logic [1:0] KIND_ERROR   = 2'd3;

	// error codes
	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_TRUNCATED = 2'd1;
	localparam logic [1:0] ERR_TOO_LONG  = 2'd2;
	localparam logic [1:0] ERR_WIRE_TYPE = 2'd3;

	// wire types
	localparam logic [2:0] WT_VARINT  = 3'd0;
	localparam logic [2:0] WT_FIXED64 = 3'd1;
	localparam logic [2:0] WT_LEN     = 3'd2;
	localparam logic [2:0] WT_FIXED32 = 3'd5;

	// varint limit in bytes
	localparam logic [3:0] VARINT_MAX = 4'd10;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       message_last;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] field_number;
		logic [2:0]  wire_type;
		logic [63:0] value;
		logic [7:0]  payload_byte;
		logic        payload_last;
		logic [1:0]  error_code;
		logic        message_end;
	} out_item_t;

	// classified byte handed from front to back
	typedef struct packed {
		logic [6:0] bits7;  // varint data bits
		logic       more;   // varint continuation bit
		logic [7:0] raw;    // whole byte for fixed and payload use
		logic       last;   // final byte of the message
	} tok_t;

endpackage

[design/pwfp_front.sv]
// ----------------------------------------------------------------------------
// pwfp_front - byte intake and token queue
// Splits each byte into varint data and continuation bit and queues it.
// ----------------------------------------------------------------------------
module pwfp_front import pwfp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_item_t data,
	output logic     tok_valid,
	output tok_t     tok,
	input  logic     tok_take
);

	tok_t              tok_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              wr_en;
	logic              rd_en;
	tok_t              tok_in;

	assign full      = (count_q == QCNT_W'(QDEPTH));
	assign tok_valid = (count_q != '0);
	assign tok       = tok_q[rd_ptr_q];
	assign wr_en     = push && !full;
	assign rd_en     = tok_take && tok_valid;

	always_comb begin
		tok_in.bits7 = data.data_byte[6:0];
		tok_in.more  = data.data_byte[7];
		tok_in.raw   = data.data_byte;
		tok_in.last  = data.message_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tok_q[wr_ptr_q] <= tok_in;
		end
	end

	// occupancy never beyond depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("front queue overfilled");

	// a write into a non-full queue with no read raises the count by one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !rd_en) |=> (count_q == $past(count_q) + 1'b1))
		else $error("front queue count out of step");

endmodule

[design/pwfp_back.sv]
// ----------------------------------------------------------------------------
// pwfp_back - field decoder and result register
// Runs the tag, varint, fixed and payload phases on each token.
// ----------------------------------------------------------------------------
module pwfp_back import pwfp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      tok_valid,
	input  tok_t      tok,
	output logic      tok_take,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	typedef enum logic [2:0] {
		PH_TAG,
		PH_VARINT,
		PH_FIX64,
		PH_FIX32,
		PH_LEN,
		PH_PAYLOAD,
		PH_DISCARD
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [63:0] acc_q, acc_n;
	logic [3:0]  cnt_q, cnt_n;
	logic [31:0] fld_q, fld_n;
	logic [2:0]  wire_q, wire_n;
	logic [63:0] rem_q, rem_n;
	logic        out_valid_q;
	out_item_t   out_q;

	logic        fire;
	logic        has_res;
	out_item_t   res;

	// varint step
	logic [6:0]  vshamt;
	logic [63:0] acc_v;
	logic [3:0]  cnt_v;
	logic        v_long, v_done;
	// fixed step
	logic [63:0] acc_f;
	logic [3:0]  need;
	// payload step
	logic [63:0] rem_d;
	logic        plast;
	// outcome flags
	logic        do_fail;
	logic [1:0]  fail_code;
	logic        do_clear;

	assign empty    = !out_valid_q;
	assign result   = out_q;
	assign fire     = tok_valid && (!out_valid_q || pop);
	assign tok_take = fire;

	always_comb begin
		vshamt = 7'(cnt_q) * 7'd7;
		acc_v  = acc_q | ({57'd0, tok.bits7} << vshamt);
		cnt_v  = cnt_q + 4'd1;
		v_long = (cnt_q > 4'd9) || (tok.more && (cnt_v >= VARINT_MAX));
		v_done = !v_long && !tok.more;
		acc_f  = acc_q;
		if (cnt_q < 4'd8) begin
			acc_f = acc_q | ({56'd0, tok.raw} << {cnt_q[2:0], 3'b000});
		end
		need  = (phase_q == PH_FIX64) ? 4'd8 : 4'd4;
		rem_d = (rem_q != 64'd0) ? rem_q - 64'd1 : 64'd0;
		plast = (rem_d == 64'd0);
	end

	always_comb begin
		phase_n   = phase_q;
		acc_n     = acc_q;
		cnt_n     = cnt_q;
		fld_n     = fld_q;
		wire_n    = wire_q;
		rem_n     = rem_q;
		has_res   = 1'b0;
		do_fail   = 1'b0;
		fail_code = ERR_NONE;
		do_clear  = 1'b0;
		res       = '0;

		case (phase_q)
			PH_TAG, PH_VARINT, PH_LEN: begin
				if (v_long) begin
					do_fail   = 1'b1;
					fail_code = ERR_TOO_LONG;
				end else if (!v_done) begin
					acc_n = acc_v;
					cnt_n = cnt_v;
					if (tok.last) begin
						do_fail   = 1'b1;
						fail_code = ERR_TRUNCATED;
					end
				end else if (phase_q == PH_TAG) begin
					fld_n  = acc_v[34:3];
					wire_n = acc_v[2:0];
					acc_n  = '0;
					cnt_n  = '0;
					case (acc_v[2:0])
						WT_VARINT:  phase_n = PH_VARINT;
						WT_FIXED64: phase_n = PH_FIX64;
						WT_LEN:     phase_n = PH_LEN;
						WT_FIXED32: phase_n = PH_FIX32;
						default: begin
							do_fail   = 1'b1;
							fail_code = ERR_WIRE_TYPE;
						end
					endcase
					if (!do_fail && tok.last) begin
						do_fail   = 1'b1;
						fail_code = ERR_TRUNCATED;
					end
				end else if (phase_q == PH_VARINT) begin
					has_res   = 1'b1;
					res.kind  = KIND_SCALAR;
					res.value = acc_v;
					do_clear  = 1'b1;
				end else if (acc_v == 64'd0) begin
					// empty payload: header alone
					has_res  = 1'b1;
					res.kind = KIND_HEADER;
					do_clear = 1'b1;
				end else if (tok.last) begin
					do_fail   = 1'b1;
					fail_code = ERR_TRUNCATED;
				end else begin
					has_res   = 1'b1;
					res.kind  = KIND_HEADER;
					res.value = acc_v;
					rem_n     = acc_v;
					acc_n     = '0;
					cnt_n     = '0;
					phase_n   = PH_PAYLOAD;
				end
			end
			PH_FIX64, PH_FIX32: begin
				if (cnt_v >= need) begin
					has_res   = 1'b1;
					res.kind  = KIND_SCALAR;
					res.value = acc_f;
					do_clear  = 1'b1;
				end else begin
					acc_n = acc_f;
					cnt_n = cnt_v;
					if (tok.last) begin
						do_fail   = 1'b1;
						fail_code = ERR_TRUNCATED;
					end
				end
			end
			PH_PAYLOAD: begin
				if (!plast && tok.last) begin
					do_fail   = 1'b1;
					fail_code = ERR_TRUNCATED;
				end else begin
					has_res          = 1'b1;
					res.kind         = KIND_PAYLOAD;
					res.payload_byte = tok.raw;
					res.payload_last = plast;
					rem_n            = rem_d;
					do_clear         = plast;
				end
			end
			PH_DISCARD: begin
				do_clear = tok.last;
			end
			default: begin
				do_clear = 1'b1;
			end
		endcase

		if (do_fail) begin
			has_res        = 1'b1;
			res            = '0;
			res.kind       = KIND_ERROR;
			res.error_code = fail_code;
			if (tok.last) begin
				do_clear = 1'b1;
			end else begin
				phase_n = PH_DISCARD;
			end
		end
		res.field_number = fld_n;
		res.wire_type    = wire_n;
		res.message_end  = tok.last;

		if (do_clear) begin
			phase_n = PH_TAG;
			acc_n   = '0;
			cnt_n   = '0;
			fld_n   = '0;
			wire_n  = '0;
			rem_n   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_TAG;
			acc_q       <= '0;
			cnt_q       <= '0;
			fld_q       <= '0;
			wire_q      <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				phase_q <= phase_n;
				acc_q   <= acc_n;
				cnt_q   <= cnt_n;
				fld_q   <= fld_n;
				wire_q  <= wire_n;
				rem_q   <= rem_n;
			end
			if (fire && has_res) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && has_res) begin
			out_q <= res;
		end
	end

	// an error result always carries a cause
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.kind == KIND_ERROR) |-> (out_q.error_code != ERR_NONE))
		else $error("error result without code");

	// payload_last only on payload bytes
	a_plast_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.payload_last) |-> (out_q.kind == KIND_PAYLOAD))
		else $error("payload_last outside payload");

	// a discarded byte never leaves a result behind
	a_discard_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && phase_q == PH_DISCARD) |=> !out_valid_q)
		else $error("result produced while discarding");

	// payload phase always has bytes still owed
	a_rem_live: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (rem_q != 64'd0))
		else $error("payload phase with nothing remaining");

endmodule

[design/protobuf_wire_field_parser_top.sv]
// ----------------------------------------------------------------------------
// protobuf_wire_field_parser_top - streaming protobuf wire-format decoder
// Byte-wide intake queue feeding a field decoder with a one-item result
// register; one result item at most per message byte.
// ----------------------------------------------------------------------------
//
//  channel   handshake        payload      notes
//  -------   --------------   ----------   --------------------------------
//  input     push / full      data         one message byte plus last mark
//  result    empty / pop      result       scalar, header, payload or error
//
// Sustained rate is one byte per cycle while the result register is not held;
// the decoder handles each byte with a 64-bit shift-or or a 64-bit decrement
// and compare. A pushed byte is first written into the 4-entry queue, then
// the decoder runs on it into the result register.
// When the result register is held (empty low, no pop) the decoder pauses;
// the queue keeps taking bytes until it holds four, then full rises.
// Bytes that give no result (tag bytes, inner varint bytes) also wait while a
// result is held and pass only once the register drains, so stalls stay in order.
// arst_n clears queue pointers, decoder phase and the result-valid flag.
//
module protobuf_wire_field_parser_top import pwfp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  data,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	logic tok_valid;
	tok_t tok;
	logic tok_take;

	// front: classify each byte and buffer it
	pwfp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.data      (data),
		.tok_valid (tok_valid),
		.tok       (tok),
		.tok_take  (tok_take)
	);

	// back: field decoding and the result register
	pwfp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (tok_valid),
		.tok       (tok),
		.tok_take  (tok_take),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for protobuf_wire_field_parser_top
// Streams encoded messages in one byte per item and predicts every decoded
// result with its own wire-format decoder. Each result popped is compared
// field by field against the oldest prediction. Both sides idle at random,
// and one long receiver hold fills the intake queue.
// ----------------------------------------------------------------------------
module tb import pwfp_pkg::*;;

	// run shape
	localparam int HOLD_CYCLES  = 60;    // long receiver hold, backpressure test
	localparam int DRAIN_CYCLES = 12;    // settle time after the last result
	localparam int GAPPY_ITEMS  = 1330;  // random part with idling on both sides
	localparam int TOTAL_ITEMS  = 1550;  // then a steady tail with no idling

	// wire types the block rejects
	localparam logic [2:0] WT_GROUP_START = 3'd3;
	localparam logic [2:0] WT_GROUP_END   = 3'd4;
	localparam logic [2:0] WT_RESERVED6   = 3'd6;
	localparam logic [2:0] WT_RESERVED7   = 3'd7;

	// decoder position within a field
	typedef enum logic [2:0] {
		AWAIT_TAG,
		IN_VARINT,
		IN_FIXED64,
		IN_FIXED32,
		IN_LENGTH,
		IN_PAYLOAD,
		SKIPPING
	} parse_stage_t;

	// outcome of folding one varint byte
	typedef enum logic [1:0] {
		VARINT_MORE,
		VARINT_DONE,
		VARINT_OVERLONG
	} varint_step_t;

	logic      clk    = 1'b0;
	logic      arst_n = 1'b0;
	logic      push   = 1'b0;
	logic      pop    = 1'b0;
	in_item_t  data   = '0;
	logic      full;
	logic      empty;
	out_item_t result;

	protobuf_wire_field_parser_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.data   (data),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor state - mirrors the decoder, reset values as after arst_n
	// ------------------------------------------------------------------
	parse_stage_t stage      = AWAIT_TAG;
	logic [63:0]  acc        = '0;
	logic [3:0]   nbytes     = '0;
	logic [31:0]  fld_no     = '0;
	logic [2:0]   fld_wire   = '0;
	logic [63:0]  bytes_left = '0;

	out_item_t  awaited_items[$];  // predicted results, oldest first
	logic [7:0] msg_q[$];          // message under construction
	int         items_sent = 0;
	int         fails      = 0;

	bit   tx_gaps    = 1'b0;
	bit   rx_gaps    = 1'b0;
	bit   holding    = 1'b0;
	int   stall_left = 0;
	event hold_kick;

	function automatic void clear_parse();
		stage      = AWAIT_TAG;
		acc        = '0;
		nbytes     = '0;
		fld_no     = '0;
		fld_wire   = '0;
		bytes_left = '0;
	endfunction

	// Seven data bits per byte, little end first; the tenth byte only
	// contributes its lowest bit, which lands at bit 63.
	function automatic varint_step_t fold_varint(logic [7:0] b);
		if (nbytes > 4'd9)
			return VARINT_OVERLONG;
		acc |= {57'd0, b[6:0]} << (7 * nbytes);
		nbytes++;
		if (!b[7])
			return VARINT_DONE;
		if (nbytes >= VARINT_MAX)
			return VARINT_OVERLONG;
		return VARINT_MORE;
	endfunction

	function automatic out_item_t pack_result(logic [1:0] kind, logic [63:0] value,
			logic [7:0] pbyte, logic plast, logic [1:0] code, logic mend);
		out_item_t r;
		r.kind         = kind;
		r.field_number = fld_no;
		r.wire_type    = fld_wire;
		r.value        = value;
		r.payload_byte = pbyte;
		r.payload_last = plast;
		r.error_code   = code;
		r.message_end  = mend;
		return r;
	endfunction

	// error result; the rest of the message is then skipped
	function automatic out_item_t flag_error(logic [1:0] code, logic last);
		out_item_t r;
		r = pack_result(KIND_ERROR, 64'd0, 8'd0, 1'b0, code, last);
		if (last)
			clear_parse();
		else
			stage = SKIPPING;
		return r;
	endfunction

	function automatic out_item_t close_field(logic [1:0] kind, logic [63:0] value,
			logic [7:0] pbyte, logic plast, logic last);
		out_item_t r;
		r = pack_result(kind, value, pbyte, plast, ERR_NONE, last);
		clear_parse();
		return r;
	endfunction

	// Advances the predictor by one message byte; hit is set when the byte
	// produces a result. Truncation is only flagged on the last byte.
	task automatic decode_byte(input logic [7:0] b, input logic last,
			output bit hit, output out_item_t r);
		varint_step_t vs;
		bit           bad_wire;
		int           need;
		hit = 1'b0;
		r   = '0;
		case (stage)
			AWAIT_TAG: begin
				vs = fold_varint(b);
				if (vs == VARINT_OVERLONG) begin
					hit = 1'b1;
					r   = flag_error(ERR_TOO_LONG, last);
				end else if (vs == VARINT_MORE) begin
					if (last) begin
						hit = 1'b1;
						r   = flag_error(ERR_TRUNCATED, last);
					end
				end else begin
					fld_no   = acc[34:3];
					fld_wire = acc[2:0];
					acc      = '0;
					nbytes   = '0;
					bad_wire = 1'b0;
					case (fld_wire)
						WT_VARINT:  stage = IN_VARINT;
						WT_FIXED64: stage = IN_FIXED64;
						WT_LEN:     stage = IN_LENGTH;
						WT_FIXED32: stage = IN_FIXED32;
						default:    bad_wire = 1'b1;
					endcase
					if (bad_wire) begin
						hit = 1'b1;
						r   = flag_error(ERR_WIRE_TYPE, last);
					end else if (last) begin
						// tag complete but the body never starts
						hit = 1'b1;
						r   = flag_error(ERR_TRUNCATED, last);
					end
				end
			end
			IN_VARINT, IN_LENGTH: begin
				vs = fold_varint(b);
				if (vs == VARINT_OVERLONG) begin
					hit = 1'b1;
					r   = flag_error(ERR_TOO_LONG, last);
				end else if (vs == VARINT_MORE) begin
					if (last) begin
						hit = 1'b1;
						r   = flag_error(ERR_TRUNCATED, last);
					end
				end else if (stage == IN_VARINT) begin
					hit = 1'b1;
					r   = close_field(KIND_SCALAR, acc, 8'd0, 1'b0, last);
				end else if (acc == 64'd0) begin
					// empty payload: header only
					hit = 1'b1;
					r   = close_field(KIND_HEADER, 64'd0, 8'd0, 1'b0, last);
				end else if (last) begin
					hit = 1'b1;
					r   = flag_error(ERR_TRUNCATED, last);
				end else begin
					hit        = 1'b1;
					r          = pack_result(KIND_HEADER, acc, 8'd0, 1'b0, ERR_NONE, 1'b0);
					bytes_left = acc;
					acc        = '0;
					nbytes     = '0;
					stage      = IN_PAYLOAD;
				end
			end
			IN_FIXED64, IN_FIXED32: begin
				need = (stage == IN_FIXED64) ? 8 : 4;
				if (nbytes < 4'd8)
					acc |= {56'd0, b} << (8 * nbytes);
				nbytes++;
				if (nbytes >= need) begin
					hit = 1'b1;
					r   = close_field(KIND_SCALAR, acc, 8'd0, 1'b0, last);
				end else if (last) begin
					hit = 1'b1;
					r   = flag_error(ERR_TRUNCATED, last);
				end
			end
			IN_PAYLOAD: begin
				if (bytes_left != 64'd0)
					bytes_left--;
				hit = 1'b1;
				if (bytes_left == 64'd0)
					r = close_field(KIND_PAYLOAD, 64'd0, b, 1'b1, last);
				else if (last)
					r = flag_error(ERR_TRUNCATED, last);
				else
					r = pack_result(KIND_PAYLOAD, 64'd0, b, 1'b0, ERR_NONE, 1'b0);
			end
			default: begin
				// skipping after an error until the message ends
				if (last)
					clear_parse();
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Sender - one item per call, driven on the falling edge
	// ------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b, input logic last);
		bit        hit;
		out_item_t want;
		if (tx_gaps && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		push <= 1'b1;
		data <= {b, last};
		@(posedge clk);
		while (full)
			@(posedge clk);
		decode_byte(b, last, hit, want);
		if (hit)
			awaited_items.push_back(want);
		items_sent++;
		@(negedge clk);
	endtask

	// sends the first n bytes of the built message, last mark on the final one
	task automatic ship(input int n);
		for (int i = 0; i < n; i++)
			send_byte(msg_q[i], i == n - 1);
		msg_q.delete();
	endtask

	// ------------------------------------------------------------------
	// Message building
	// ------------------------------------------------------------------
	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [63:0] rand_value();
		case ($urandom_range(0, 7))
			0:       return 64'd0;
			1:       return '1;
			default: return {$urandom, $urandom} >> $urandom_range(0, 63);
		endcase
	endfunction

	function automatic int varint_len(logic [63:0] v);
		int n;
		n = 1;
		while (n < 10 && (v >> (7 * n)) != 64'd0)
			n++;
		return n;
	endfunction

	// minimal length most of the time, now and then padded up to ten bytes
	function automatic int pick_len(logic [63:0] v);
		int n;
		n = varint_len(v);
		if ($urandom_range(0, 9) == 0)
			n = $urandom_range(n, 10);
		return n;
	endfunction

	// n-byte varint; a tenth byte carries junk in the bits that get dropped
	function automatic void add_varint(logic [63:0] v, int n);
		logic [7:0] b;
		for (int k = 0; k < n; k++) begin
			b = {1'b0, 7'((v >> (7 * k)) & 64'h7f)};
			if (k == 9)
				b = {1'b0, 6'($urandom_range(0, 63)), v[63]};
			if (k < n - 1)
				b[7] = 1'b1;
			msg_q.push_back(b);
		end
	endfunction

	function automatic void add_tag(logic [31:0] fld, logic [2:0] wt);
		logic [63:0] tag;
		tag = {29'd0, fld, wt};
		add_varint(tag, varint_len(tag));
	endfunction

	function automatic void add_fixed(logic [63:0] v, int n);
		for (int k = 0; k < n; k++)
			msg_q.push_back(v[8 * k +: 8]);
	endfunction

	// ten continuation bytes: too long wherever it stands
	function automatic void add_overlong();
		repeat (10)
			msg_q.push_back(rand_byte() | 8'h80);
	endfunction

	function automatic void add_noise(int n);
		repeat (n)
			msg_q.push_back(rand_byte());
	endfunction

	function automatic logic [2:0] good_wire();
		case ($urandom_range(0, 3))
			0:       return WT_VARINT;
			1:       return WT_FIXED64;
			2:       return WT_LEN;
			default: return WT_FIXED32;
		endcase
	endfunction

	function automatic logic [2:0] bad_wire_type();
		case ($urandom_range(0, 3))
			0:       return WT_GROUP_START;
			1:       return WT_GROUP_END;
			2:       return WT_RESERVED6;
			default: return WT_RESERVED7;
		endcase
	endfunction

	function automatic void add_random_field();
		logic [31:0] fld;
		logic [2:0]  wt;
		logic [63:0] tag;
		int          len;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: fld = $urandom_range(1, 15);
			8:                fld = '0;
			default:          fld = $urandom;
		endcase
		wt  = good_wire();
		tag = {29'd0, fld, wt};
		// bits above the 32-bit field number get cut off by the decoder
		if ($urandom_range(0, 9) == 0) begin
			tag      = {$urandom, $urandom};
			tag[2:0] = wt;
		end
		add_varint(tag, pick_len(tag));
		case (wt)
			WT_VARINT: begin
				tag = rand_value();
				add_varint(tag, pick_len(tag));
			end
			WT_FIXED64: add_fixed(rand_value(), 8);
			WT_FIXED32: add_fixed(rand_value(), 4);
			default: begin
				len = ($urandom_range(0, 6) != 0) ? $urandom_range(0, 6) : $urandom_range(7, 24);
				add_varint(64'(len), pick_len(64'(len)));
				add_noise(len);
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// scalar, header and payload results: scalar zero, fixed32 all ones, empty payload,
	// and a one-byte payload ending the message
	task automatic test_field_kinds();
		add_tag(1, WT_VARINT);
		add_varint(64'd0, 1);
		add_tag(2, WT_FIXED32);
		add_fixed('1, 4);
		add_tag(3, WT_LEN);
		add_varint(64'd0, 1);
		add_tag(4, WT_LEN);
		add_varint(64'd1, 1);
		msg_q.push_back(8'h80);
		ship(msg_q.size());
	endtask

	// truncated fixed64, unsupported wire type with skipped bytes after it,
	// and a tag that runs to ten continuation bytes
	task automatic test_error_cases();
		add_tag(1, WT_FIXED64);
		add_fixed(64'h0201, 2);
		ship(msg_q.size());
		add_tag(1, WT_GROUP_START);
		msg_q.push_back(8'h00);
		msg_q.push_back(8'hff);
		ship(msg_q.size());
		repeat (10)
			msg_q.push_back(8'hff);
		ship(msg_q.size());
	endtask

	// Receiver holds off for a long stretch while a long payload streams in:
	// the intake queue fills and full has to hold the sender back.
	task automatic test_backpressure();
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		-> hold_kick;
		add_tag(7, WT_LEN);
		add_varint(64'd40, 1);
		add_noise(40);
		add_tag(8, WT_VARINT);
		add_varint(rand_value(), 10);
		ship(msg_q.size());
	endtask

	// mostly well-formed messages with random content; the rest truncated,
	// bad wire types, over-long varints and plain noise
	task automatic send_random_message();
		int sel;
		sel = $urandom_range(0, 99);
		repeat ($urandom_range(1, 3))
			add_random_field();
		if (sel < 68) begin
			ship(msg_q.size());
		end else if (sel < 84) begin
			if ($urandom_range(0, 4) == 0) begin
				// length far beyond what the message holds
				add_tag($urandom_range(1, 15), WT_LEN);
				add_varint({$urandom, $urandom} | 64'h100, 10);
				add_noise($urandom_range(1, 4));
				ship(msg_q.size());
			end else begin
				ship($urandom_range(1, msg_q.size()));
			end
		end else if (sel < 90) begin
			add_tag($urandom_range(1, 31), bad_wire_type());
			add_noise($urandom_range(0, 3));
			ship(msg_q.size());
		end else if (sel < 96) begin
			case ($urandom_range(0, 2))
				0: ;
				1: add_tag($urandom_range(1, 15), WT_VARINT);
				default: add_tag($urandom_range(1, 15), WT_LEN);
			endcase
			add_overlong();
			add_noise($urandom_range(0, 3));
			ship(msg_q.size());
		end else begin
			msg_q.delete();
			add_noise($urandom_range(1, 8));
			ship(msg_q.size());
		end
	endtask

	task automatic test_random_messages();
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		while (items_sent < GAPPY_ITEMS)
			send_random_message();
	endtask

	// closing stretch at full rate, no idling on either side
	task automatic test_steady_stream();
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		while (items_sent < TOTAL_ITEMS)
			send_random_message();
	endtask

	// ------------------------------------------------------------------
	// Receiver - pop decided on the falling edge
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (holding) begin
			pop <= 1'b0;
		end else if (stall_left > 0) begin
			pop <= 1'b0;
			stall_left--;
		end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
			pop <= 1'b0;
			stall_left = $urandom_range(0, 4);
		end else begin
			pop <= 1'b1;
		end
	end

	// long hold, counted here in cycles
	always begin
		@(hold_kick);
		holding = 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		holding = 1'b0;
	end

	// ------------------------------------------------------------------
	// Result checker - sampled on the rising edge
	// ------------------------------------------------------------------
	task automatic check_field(input string what, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
			fails++;
		end
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && pop && !empty) begin
			if (awaited_items.size() == 0) begin
				$display("%0t: unexpected result %h", $time, result);
				fails++;
			end else begin
				want = awaited_items.pop_front();
				check_field("kind", 64'(want.kind), 64'(result.kind));
				check_field("field_number", 64'(want.field_number),
					64'(result.field_number));
				check_field("wire_type", 64'(want.wire_type), 64'(result.wire_type));
				check_field("value", want.value, result.value);
				check_field("payload_byte", 64'(want.payload_byte),
					64'(result.payload_byte));
				check_field("payload_last", 64'(want.payload_last),
					64'(result.payload_last));
				check_field("error_code", 64'(want.error_code), 64'(result.error_code));
				check_field("message_end", 64'(want.message_end),
					64'(result.message_end));
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		clear_parse();
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_field_kinds();
		test_error_cases();
		test_backpressure();
		test_random_messages();
		test_steady_stream();

		push <= 1'b0;
		while (awaited_items.size() != 0)
			@(posedge clk);
		// catch anything stray after the last predicted result
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#2000000;
		$display("tb NOT OK");
		$finish;
	end

endmodule

[protobuf_wire_field_parser_top.f]
design/pwfp_pkg.sv
design/pwfp_front.sv
design/pwfp_back.sv
design/protobuf_wire_field_parser_top.sv
tb/tb.sv
